FILE: hw/rtl/lst_pkg.sv
// Shared types and constants for the light spike trigger.
// Used by lst_cell, lst_detect and light_spike_trigger; no dependencies.
package lst_pkg;

  // number of photo sensors: left, right, back
  localparam int SENSORS = 3;
  // width of a sample field on the input channel
  localparam int IN_W = 10;
  // width of a threshold register
  localparam int THRESH_W = 10;
  // width of the speed register
  localparam int SPEED_W = 8;

  // control handed from the top level to every window cell and detector
  typedef struct packed {
    logic load;   // first transaction: fill the whole window with the sample
    logic shift;  // later transaction: shift the sample in, drop the oldest
  } cell_ctl_t;

endpackage

FILE: hw/rtl/lst_cell.sv
// One tap of the sample window: holds one sample per sensor.
// Depends on lst_pkg for the control struct and the sensor count.
module lst_cell #(
  parameter int SAMPLE_BITS = 10
) (
  input  logic                                         clk,
  input  lst_pkg::cell_ctl_t                           ctl,
  input  logic [lst_pkg::SENSORS-1:0][SAMPLE_BITS-1:0] fill,
  input  logic [lst_pkg::SENSORS-1:0][SAMPLE_BITS-1:0] prev,
  output logic [lst_pkg::SENSORS-1:0][SAMPLE_BITS-1:0] tap
);

  // load the new sample on priming, otherwise take the neighbor's sample
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      tap <= fill;
    end else if (ctl.shift) begin
      tap <= prev;
    end
  end

endmodule

FILE: hw/rtl/lst_detect.sv
// Running window sum, floor average and rise compare for one sensor.
// Depends on lst_pkg for the control struct and the threshold width.
module lst_detect #(
  parameter int WINDOW      = 10,
  parameter int SAMPLE_BITS = 10
) (
  input  logic                         clk,
  input  lst_pkg::cell_ctl_t           ctl,
  input  logic [SAMPLE_BITS-1:0]       sample,
  input  logic [SAMPLE_BITS-1:0]       oldest,
  input  logic [lst_pkg::THRESH_W-1:0] threshold,
  output logic                         rise
);

  localparam int LOG_W  = $clog2(WINDOW);
  localparam int SUM_W  = SAMPLE_BITS + LOG_W;
  // reciprocal with one extra bit of precision: exact floor for any sum
  localparam int SHIFT  = SUM_W + LOG_W;
  localparam int MULT_W = SUM_W + 1;
  localparam int PROD_W = SUM_W + MULT_W;
  localparam logic [MULT_W-1:0] RECIP =
    MULT_W'(((64'd1 << SHIFT) + 64'(WINDOW) - 64'd1) / 64'(WINDOW));
  localparam int CMP_W  = ((SAMPLE_BITS > lst_pkg::THRESH_W) ?
                           SAMPLE_BITS : lst_pkg::THRESH_W) + 1;

  logic [SUM_W-1:0]       window_sum;
  logic [SUM_W-1:0]       window_sum_next;
  logic [PROD_W-1:0]      product;
  logic [SAMPLE_BITS-1:0] average;
  logic [CMP_W-1:0]       limit;

  // update the running sum: full fill on priming, else drop oldest, add new
  always_comb begin
    window_sum_next = window_sum;
    if (ctl.load) begin
      window_sum_next = SUM_W'(SUM_W'(sample) * SUM_W'(WINDOW));
    end else if (ctl.shift) begin
      window_sum_next = window_sum - SUM_W'(oldest) + SUM_W'(sample);
    end
  end

  always_ff @(posedge clk) begin
    window_sum <= window_sum_next;
  end

  // floor average of the stored window through the reciprocal
  assign product = PROD_W'(window_sum) * PROD_W'(RECIP);
  assign average = SAMPLE_BITS'(product >> SHIFT);

  // rise above average beyond the threshold
  assign limit = CMP_W'(average) + CMP_W'(threshold);
  assign rise  = CMP_W'(sample) > limit;

endmodule

FILE: hw/rtl/light_spike_trigger.sv
// Top level of the light spike trigger: window chain, detectors, output stage.
// Depends on lst_pkg, lst_cell and lst_detect.
//
// Usage:
//   s_axis carries one tick per transaction with three sensor samples.
//   m_axis returns exactly one result per input transaction: the fire mask,
//   the motor action and the drive speed.
//   cfg_we / cfg_index / cfg_data write the thresholds (index 0..2) and the
//   drive speed (index 3); other indexes are ignored. Write only while idle.
// Timing:
//   m_axis_tvalid rises in the cycle after the input transaction.
//   Throughput is one transaction per cycle while m_axis_tready is high; the
//   window shifts in a chain of WINDOW cells, each sensor keeps a running sum,
//   so the average costs one constant reciprocal multiply per sensor per cycle.
// Reset:
//   rst clears the priming flag, reloads the holdoff count to WINDOW and
//   restores the register defaults. The first transaction fills the window.
//   Firing stays off for the first WINDOW transactions.
// Stall:
//   The result sits in the output register; s_axis_tready is high whenever
//   that register is empty or being drained in the same cycle.
module light_spike_trigger #(
  parameter int WINDOW      = 10,
  parameter int SAMPLE_BITS = 10
) (
  input  logic        clk,
  input  logic        rst,
  // tdata: sample_left [9:0], sample_right [19:10], sample_back [29:20]
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,
  // tdata: fire_mask [2:0], action [5:3], speed [13:6]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [9:0]  cfg_data
);

  localparam int NS   = lst_pkg::SENSORS;
  localparam int HO_W = $clog2(WINDOW + 1);

  // register indexes
  localparam logic [2:0] REG_THRESH_LEFT  = 3'd0;
  localparam logic [2:0] REG_THRESH_RIGHT = 3'd1;
  localparam logic [2:0] REG_THRESH_BACK  = 3'd2;
  localparam logic [2:0] REG_DRIVE_SPEED  = 3'd3;

  // register defaults
  localparam logic [lst_pkg::THRESH_W-1:0] THRESH_LEFT_RST  = 10'd60;
  localparam logic [lst_pkg::THRESH_W-1:0] THRESH_RIGHT_RST = 10'd60;
  localparam logic [lst_pkg::THRESH_W-1:0] THRESH_BACK_RST  = 10'd80;
  localparam logic [lst_pkg::SPEED_W-1:0]  SPEED_RST        = 8'd100;

  // motor actions
  localparam logic [2:0] ACT_STOP      = 3'd0;
  localparam logic [2:0] ACT_LEFT      = 3'd1;
  localparam logic [2:0] ACT_RIGHT     = 3'd2;
  localparam logic [2:0] ACT_FORWARD   = 3'd3;
  localparam logic [2:0] ACT_NO_CHANGE = 3'd4;

  // fire mask codes
  localparam logic [2:0] MASK_NONE  = 3'b000;
  localparam logic [2:0] MASK_LEFT  = 3'b001;
  localparam logic [2:0] MASK_RIGHT = 3'b010;
  localparam logic [2:0] MASK_BOTH  = 3'b011;

  logic [NS-1:0][lst_pkg::THRESH_W-1:0] threshold;
  logic [lst_pkg::SPEED_W-1:0]          drive_speed;
  logic                                 primed;
  logic [HO_W-1:0]                      holdoff;
  logic                                 s_fire;
  lst_pkg::cell_ctl_t                   ctl;
  logic [NS-1:0][SAMPLE_BITS-1:0]       sample;
  logic [NS-1:0][SAMPLE_BITS-1:0]       taps [WINDOW];
  logic [NS-1:0]                        rise;
  logic [2:0]                           mask_next;
  logic [2:0]                           action_next;
  logic [2:0]                           fire_mask;
  logic [2:0]                           action;
  logic [lst_pkg::SPEED_W-1:0]          speed;

  // accept whenever the output register is free or draining
  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign ctl.load      = s_fire && !primed;
  assign ctl.shift     = s_fire && primed;

  // reduce the samples to the working width
  assign sample[0] = SAMPLE_BITS'(s_axis_tdata[9:0]);
  assign sample[1] = SAMPLE_BITS'(s_axis_tdata[19:10]);
  assign sample[2] = SAMPLE_BITS'(s_axis_tdata[29:20]);

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      threshold[0] <= THRESH_LEFT_RST;
      threshold[1] <= THRESH_RIGHT_RST;
      threshold[2] <= THRESH_BACK_RST;
      drive_speed  <= SPEED_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_THRESH_LEFT:  threshold[0] <= cfg_data;
        REG_THRESH_RIGHT: threshold[1] <= cfg_data;
        REG_THRESH_BACK:  threshold[2] <= cfg_data;
        REG_DRIVE_SPEED:  drive_speed  <= cfg_data[lst_pkg::SPEED_W-1:0];
        default: ;
      endcase
    end
  end

  // priming flag and holdoff count
  always_ff @(posedge clk) begin
    if (rst) begin
      primed  <= 1'b0;
      holdoff <= HO_W'(WINDOW);
    end else if (s_fire) begin
      primed <= 1'b1;
      if (holdoff != '0) begin
        holdoff <= holdoff - HO_W'(1);
      end
    end
  end

  // window chain: cell 0 takes the new sample, the last cell holds the oldest
  for (genvar k = 0; k < WINDOW; k++) begin : g_cell
    lst_cell #(.SAMPLE_BITS(SAMPLE_BITS)) u_cell (
      .clk  (clk),
      .ctl  (ctl),
      .fill (sample),
      .prev ((k == 0) ? sample : taps[(k == 0) ? 0 : k - 1]),
      .tap  (taps[k])
    );
  end

  // one detector per sensor
  for (genvar i = 0; i < NS; i++) begin : g_det
    lst_detect #(.WINDOW(WINDOW), .SAMPLE_BITS(SAMPLE_BITS)) u_det (
      .clk       (clk),
      .ctl       (ctl),
      .sample    (sample[i]),
      .oldest    (taps[WINDOW-1][i]),
      .threshold (threshold[i]),
      .rise      (rise[i])
    );
  end

  // gate firing during holdoff and map the mask to an action
  always_comb begin
    mask_next = (holdoff == '0) ? rise : MASK_NONE;
    case (mask_next)
      MASK_NONE:  action_next = ACT_STOP;
      MASK_LEFT:  action_next = ACT_LEFT;
      MASK_RIGHT: action_next = ACT_RIGHT;
      MASK_BOTH:  action_next = ACT_FORWARD;
      default:    action_next = ACT_NO_CHANGE;
    endcase
  end

  // output register: hold until the receiver takes the transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (s_axis_tready) begin
      m_axis_tvalid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_fire) begin
      fire_mask <= mask_next;
      action    <= action_next;
      speed     <= drive_speed;
    end
  end

  assign m_axis_tdata = {2'b00, speed, action, fire_mask};

  // a result with any fire bit must come after the holdoff ran out
  a_fire_after_holdoff: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && fire_mask != MASK_NONE) |-> (holdoff == '0))
    else $error("fire bit set before holdoff expired");

  // action always matches the mask that was sent
  a_action_matches: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (fire_mask[2] ? (action == ACT_NO_CHANGE)
                                    : (action == fire_mask)))
    else $error("action does not match fire mask");

  // holdoff does not move before the window is primed
  a_holdoff_unprimed: assert property (@(posedge clk) disable iff (rst)
    !primed |-> (holdoff == HO_W'(WINDOW)))
    else $error("holdoff changed before priming");

  // a new result appears only after an input transaction
  a_result_from_input: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(s_fire))
    else $error("result without input transaction");

endmodule

FILE: verif/lst_spike_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the light spike trigger: shared codes plus a checker that
// follows both stream channels and the register port. Depends on lst_pkg.
package lst_tb_pkg;

  // window length and sample width the block is built with
  localparam int WIN_LEN  = 10;
  localparam int SAMPLE_W = 10;

  // register indexes on the configuration port
  typedef enum logic [2:0] {
    REG_THRESH_LEFT  = 3'd0,
    REG_THRESH_RIGHT = 3'd1,
    REG_THRESH_BACK  = 3'd2,
    REG_SPEED        = 3'd3
  } lst_reg_e;

  // motor actions carried in the result
  typedef enum logic [2:0] {
    ACT_STOP       = 3'd0,
    ACT_TURN_LEFT  = 3'd1,
    ACT_TURN_RIGHT = 3'd2,
    ACT_FORWARD    = 3'd3,
    ACT_NO_CHANGE  = 3'd4
  } lst_action_e;

  // register values after reset
  localparam int THRESH_LEFT_RST  = 60;
  localparam int THRESH_RIGHT_RST = 60;
  localparam int THRESH_BACK_RST  = 80;
  localparam int SPEED_RST        = 100;

  typedef struct packed {
    logic [7:0]  speed;
    lst_action_e action;
    logic [2:0]  fire_mask;
  } motor_cmd_t;

endpackage

module lst_spike_checker
  import lst_pkg::*;
  import lst_tb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [15:0] m_axis_tdata,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [9:0]  cfg_data,
  output int          fails,
  output int          pending
);

  // own copy of the sensor windows and registers
  logic [SAMPLE_W-1:0] win [SENSORS][WIN_LEN];
  int                  win_sum [SENSORS];
  logic                primed;
  int                  holdoff;
  int                  wpos;
  int                  thresh [SENSORS];
  logic [SPEED_W-1:0]  speed;

  motor_cmd_t          cmds_due [$];
  motor_cmd_t          want;

  // one tick: average before the new sample, fire test, then shift it in
  task automatic advance_window(input logic [31:0] tdata);
    logic [SAMPLE_W-1:0] smp [SENSORS];
    logic [2:0]          mask;
    int                  rise;
    motor_cmd_t          cmd;
    for (int i = 0; i < SENSORS; i++) smp[i] = tdata[i*IN_W +: SAMPLE_W];
    // first tick fills every window with its own sample
    if (!primed) begin
      primed = 1'b1;
      for (int i = 0; i < SENSORS; i++) begin
        for (int k = 0; k < WIN_LEN; k++) win[i][k] = smp[i];
        win_sum[i] = smp[i] * WIN_LEN;
      end
      wpos = 0;
    end
    mask = '0;
    for (int i = 0; i < SENSORS; i++) begin
      rise = int'(smp[i]) - win_sum[i] / WIN_LEN;
      if (holdoff == 0 && rise > thresh[i]) mask[i] = 1'b1;
      win_sum[i] = win_sum[i] - int'(win[i][wpos]) + int'(smp[i]);
      win[i][wpos] = smp[i];
    end
    wpos = (wpos + 1 >= WIN_LEN) ? 0 : wpos + 1;
    if (holdoff > 0) holdoff--;
    // back sensor overrides the steering choice
    cmd.fire_mask = mask;
    cmd.action    = mask[2] ? ACT_NO_CHANGE : lst_action_e'({1'b0, mask[1:0]});
    cmd.speed     = speed;
    cmds_due.push_back(cmd);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      primed    = 1'b0;
      holdoff   = WIN_LEN;
      wpos      = 0;
      thresh[0] = THRESH_LEFT_RST;
      thresh[1] = THRESH_RIGHT_RST;
      thresh[2] = THRESH_BACK_RST;
      speed     = SPEED_W'(SPEED_RST);
      fails     = 0;
      cmds_due.delete();
    end else begin
      // compare the result transaction against the oldest prediction
      if (m_axis_tvalid && m_axis_tready) begin
        if (cmds_due.size() == 0) begin
          $error("result transaction with nothing due: tdata %h", m_axis_tdata);
          fails++;
        end else begin
          want = cmds_due.pop_front();
          if (m_axis_tdata[2:0] !== want.fire_mask) begin
            $error("fire_mask expected %0d actual %0d", want.fire_mask, m_axis_tdata[2:0]);
            fails++;
          end
          if (m_axis_tdata[5:3] !== want.action) begin
            $error("action expected %0d actual %0d", want.action, m_axis_tdata[5:3]);
            fails++;
          end
          if (m_axis_tdata[13:6] !== want.speed) begin
            $error("speed expected %0d actual %0d", want.speed, m_axis_tdata[13:6]);
            fails++;
          end
        end
      end
      // track register writes; unknown indexes are dropped
      if (cfg_we) begin
        case (cfg_index)
          REG_THRESH_LEFT:  thresh[0] = int'(cfg_data);
          REG_THRESH_RIGHT: thresh[1] = int'(cfg_data);
          REG_THRESH_BACK:  thresh[2] = int'(cfg_data);
          REG_SPEED:        speed     = cfg_data[7:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) advance_window(s_axis_tdata);
    end
    pending = cmds_due.size();
  end

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 100ps
// Stimulus and verdict for the light spike trigger.
// Depends on lst_pkg, lst_tb_pkg, lst_spike_checker and light_spike_trigger.
module testbench;
  import lst_pkg::*;
  import lst_tb_pkg::*;

  localparam int LIMIT       = 100000;
  localparam int HOLD_CYCLES = 80;
  localparam int PHASES      = 6;
  localparam int PHASE_ITEMS = 100;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [9:0]  cfg_data;

  int          fails;
  int          pending;
  int          cycle_count = 0;
  logic        idle_on;
  logic        hold_go;
  logic        hold_done;
  int          thr_now [SENSORS];
  int          lvl [SENSORS];

  light_spike_trigger #(
    .WINDOW      (WIN_LEN),
    .SAMPLE_BITS (SAMPLE_W)
  ) i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  lst_spike_checker i_checker (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .fails         (fails),
    .pending       (pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // give up on a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // result side: random back-pressure, one long hold-off on request
  initial begin
    m_axis_tready = 1'b0;
    hold_done     = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_go && !hold_done) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_done = 1'b1;
      end else if (idle_on && $urandom_range(0, 99) < 27) begin
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // offer one tick, idling first at random, and wait for the transaction
  task automatic send_tick(input logic [9:0] left, input logic [9:0] right,
                           input logic [9:0] back);
    @(negedge clk);
    while (idle_on && $urandom_range(0, 99) < 27) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, back, right, left};
    do @(posedge clk); while (!s_axis_tready);
  endtask

  task automatic set_reg(input logic [2:0] idx, input logic [9:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // drop valid and hold until every result is back
  task automatic wait_drained();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_thresholds(input int l, input int r, input int b);
    thr_now[0] = l;
    thr_now[1] = r;
    thr_now[2] = b;
    set_reg(REG_THRESH_LEFT, 10'(l));
    set_reg(REG_THRESH_RIGHT, 10'(r));
    set_reg(REG_THRESH_BACK, 10'(b));
  endtask

  // sample near the sensor's level, sometimes a spike near its threshold
  function automatic logic [9:0] shaped_sample(input int base, input int thr);
    int v;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 10) v = $urandom_range(0, 1023);
    else if (pick < 25) v = base + thr + int'($urandom_range(0, 60)) - 20;
    else v = base + int'($urandom_range(0, 16)) - 8;
    if (v < 0) v = 0;
    if (v > 1023) v = 1023;
    return v[9:0];
  endfunction

  initial begin
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    cfg_we        = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    idle_on       = 1'b1;
    hold_go       = 1'b0;
    thr_now[0]    = THRESH_LEFT_RST;
    thr_now[1]    = THRESH_RIGHT_RST;
    thr_now[2]    = THRESH_BACK_RST;
    repeat (7) @(negedge clk);
    rst <= 1'b0;

    // priming tick, then the holdoff window where spikes must stay silent
    send_tick(10'd300, 10'd300, 10'd300);
    for (int i = 1; i < WIN_LEN; i++) begin
      if (i == 4) send_tick(10'd1023, 10'd1023, 10'd1023);
      else send_tick(10'd300, 10'd300, 10'd300);
    end
    // each nonzero mask pattern under default thresholds, then a deep dip and a right spike
    send_tick(10'd1023, 10'd300, 10'd300);
    send_tick(10'd300, 10'd1023, 10'd300);
    send_tick(10'd1023, 10'd1023, 10'd300);
    send_tick(10'd300, 10'd300, 10'd1023);
    send_tick(10'd1023, 10'd300, 10'd1023);
    send_tick(10'd300, 10'd1023, 10'd1023);
    send_tick(10'd1023, 10'd1023, 10'd1023);
    send_tick(10'd0, 10'd0, 10'd0);
    send_tick(10'd0, 10'd1023, 10'd0);
    wait_drained();

    // random phases, each under its own register setting
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin
          set_thresholds(0, 0, 0);
          set_reg(REG_SPEED, 10'd0);
          // unknown index must leave every register alone
          set_reg(3'(REG_SPEED) + 3'($urandom_range(1, 4)), 10'($urandom));
        end
        1: begin
          set_thresholds(1023, 1023, 1023);
          set_reg(REG_SPEED, {2'b11, 8'd255});
        end
        default: begin
          set_thresholds($urandom_range(0, 200), $urandom_range(0, 200),
                         $urandom_range(0, 200));
          set_reg(REG_SPEED, 10'($urandom));
        end
      endcase
      idle_on <= (p != 2);
      if (p == 3) hold_go <= 1'b1;
      for (int s = 0; s < SENSORS; s++) lvl[s] = $urandom_range(0, 700);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // let a sensor's light level wander now and then
        if ($urandom_range(0, 99) < 5) lvl[$urandom_range(0, SENSORS - 1)] =
          $urandom_range(0, 1023);
        send_tick(shaped_sample(lvl[0], thr_now[0]), shaped_sample(lvl[1], thr_now[1]),
                  shaped_sample(lvl[2], thr_now[2]));
      end
      wait_drained();
    end

    if (fails == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/lst_pkg.sv
hw/rtl/lst_cell.sv
hw/rtl/lst_detect.sv
hw/rtl/light_spike_trigger.sv
verif/lst_spike_checker.sv
verif/testbench.sv
